[rtl/core/rsc_pkg.sv]
// shared types, constants and codes for the rgb to sigmoid coefficient block
// no dependencies
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int GRID_SIZE_DEF = 16;

  localparam int CH_W   = 16;
  localparam int COEF_W = 40;
  localparam int IDX_W  = 4;
  localparam int NODE_W = 16;

  // serial divider sizing
  localparam int DIV_DVD_W = 52;
  localparam int DIV_DSR_W = 24;
  localparam int DIV_Q_W   = 40;
  localparam int DIV_CNT_W = 6;

  localparam int GRAY_QBITS = 36;
  localparam int DZ_QBITS   = 16;

  localparam int SQRT_W = 46;

  localparam logic [1:0] OP_WR_COEF = 2'd0;
  localparam logic [1:0] OP_WR_NODE = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [15:0] HALF_Q15 = 16'd16384;
  localparam logic [16:0] ONE_Q15  = 17'd32768;
  localparam logic [16:0] ONE_Q16  = 17'd65536;

  localparam logic signed [39:0] COEF_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] COEF_MIN = 40'sh80_0000_0000;

  typedef enum logic [1:0] {
    KIND_COEF,
    KIND_NODE,
    KIND_GRAY,
    KIND_COLOR
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [1:0]         ech;
    logic [3:0]         ex;
    logic [3:0]         ey;
    logic [3:0]         ez;
    logic [1:0]         comp;
    logic signed [39:0] evalue;
    logic [15:0]        nvalue;
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQRT,
    ST_GDIV_GO,
    ST_GDIV_WAIT,
    ST_XDIV_GO,
    ST_XDIV_WAIT,
    ST_YDIV_GO,
    ST_YDIV_WAIT,
    ST_CELL,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_N0_RD,
    ST_N1_RD,
    ST_N_CAP,
    ST_DZ_CHK,
    ST_DZ_WAIT,
    ST_T_RD,
    ST_T_CAP,
    ST_L_MUL,
    ST_L_ADD,
    ST_OUT
  } back_state_t;

endpackage

[rtl/core/rgb_to_sigmoid_coefficients_top.sv]
// top level of the rgb to sigmoid coefficient converter
// depends on rsc_pkg, rsc_front, rsc_back (and through it rsc_ram, rsc_divider)
`timescale 1ns / 1ps

// usage
//   an item is taken on a rising edge with start high and busy low; opcode picks
//   a coefficient table write, a z node write or an rgb conversion
//   writes with a channel or component above 2 or an index at or above the grid
//   size, and the unused opcode, are taken and dropped
//   a conversion gives one result: done is high for exactly one cycle with
//   coef_zero, coef_one, coef_two valid; the receiver cannot hold it off
//   items first enter a two deep queue, so busy only rises when the queue is full
//   writes retire straight from the queue head while the sequencer is idle
//   steps of a conversion, from queue head to done:
//     gray black or white goes straight to the result
//     gray midtones: 23 square root steps, then 36 divider steps
//     other colors: two serial divisions of 16 + log2(grid) steps, a node
//     search with a read and a compare state per probe, a serial dz division
//     of 16 steps when dz is strictly inside (0, 1), then 24 coefficient reads
//     and 21 lerps, each a multiply and an add state, through the single
//     coefficient ram read port and one lerp multiplier
//   a conversion runs to its result before the next queued item is taken; the
//   serial divider and the single ram read port set its pace
//   reset clears the queue and the sequencer; both tables hold garbage until
//   written and need no clearing pass
module rgb_to_sigmoid_coefficients_top #(
  parameter int GRID_SIZE = rsc_pkg::GRID_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [15:0]        red,
  input  logic [15:0]        green,
  input  logic [15:0]        blue,
  input  logic [1:0]         entry_channel,
  input  logic [3:0]         entry_x,
  input  logic [3:0]         entry_y,
  input  logic [3:0]         entry_z,
  input  logic [1:0]         entry_component,
  input  logic signed [39:0] entry_value,
  input  logic [15:0]        node_value,
  output logic               done,
  output logic signed [39:0] coef_zero,
  output logic signed [39:0] coef_one,
  output logic signed [39:0] coef_two
);

  // queue head between front and back
  rsc_pkg::item_t head;
  logic           head_valid;
  logic           pop;

  // front: accept, drop ignored items, classify gray vs color, queue
  rsc_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .red(red), .green(green), .blue(blue),
    .entry_channel(entry_channel), .entry_x(entry_x), .entry_y(entry_y),
    .entry_z(entry_z), .entry_component(entry_component),
    .entry_value(entry_value), .node_value(node_value),
    .pop(pop), .head_valid(head_valid), .head(head)
  );

  // back: table writes and the conversion sequencer
  rsc_back #(.GRID_SIZE(GRID_SIZE)) u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head), .pop(pop),
    .done(done), .coef_zero(coef_zero), .coef_one(coef_one), .coef_two(coef_two)
  );

  // out of reset nothing is pending
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("done or busy right after reset");

  // every result passes through the idle state, so strobes never touch
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // the queue only fills through an accepted item
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy)
    else $error("busy rose with no item taken");

endmodule

[rtl/core/rsc_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rsc_divider.sv]
// restoring divider, one quotient bit per cycle, quotient width chosen per use
// depends on rsc_pkg
`timescale 1ns / 1ps

module rsc_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rsc_pkg::DIV_DVD_W-1:0] dividend,
  input  logic [rsc_pkg::DIV_DSR_W-1:0] divisor,
  input  logic [rsc_pkg::DIV_CNT_W-1:0] nbits,
  output logic                          done,
  output logic [rsc_pkg::DIV_Q_W-1:0]   quotient
);

  localparam int DVW = rsc_pkg::DIV_DVD_W;
  localparam int QW  = rsc_pkg::DIV_Q_W;
  localparam int SW  = rsc_pkg::DIV_DSR_W + rsc_pkg::DIV_Q_W;
  localparam int CW  = rsc_pkg::DIV_CNT_W;

  logic [DVW-1:0] rem;
  logic [SW-1:0]  dsh;
  logic [QW-1:0]  quo;
  logic [CW-1:0]  cnt;
  logic           run;
  logic           ge;

  assign ge       = SW'(rem) >= dsh;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CW'(1));
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == CW'(1))) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= SW'(divisor) << (nbits - CW'(1));
      quo <= '0;
      cnt <= nbits;
    end else if (run) begin
      if (ge) begin
        rem <= rem - dsh[DVW-1:0];
      end
      quo <= {quo[QW-2:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt - CW'(1);
    end
  end

endmodule

[rtl/core/rsc_front.sv]
// front end: takes items, drops ignored ones, classifies and queues the rest
// depends on rsc_pkg
`timescale 1ns / 1ps

module rsc_front #(
  parameter int GRID_SIZE = rsc_pkg::GRID_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode,
  input  logic [15:0]         red,
  input  logic [15:0]         green,
  input  logic [15:0]         blue,
  input  logic [1:0]          entry_channel,
  input  logic [3:0]          entry_x,
  input  logic [3:0]          entry_y,
  input  logic [3:0]          entry_z,
  input  logic [1:0]          entry_component,
  input  logic signed [39:0]  entry_value,
  input  logic [15:0]         node_value,
  input  logic                pop,
  output logic                head_valid,
  output rsc_pkg::item_t      head
);

  rsc_pkg::item_t slot [2];
  rsc_pkg::item_t itm;
  logic [1:0]     count;
  logic           wp;
  logic           rp;
  logic           keep;
  logic           push;

  always_comb begin
    itm.kind   = rsc_pkg::KIND_COEF;
    itm.red    = red;
    itm.green  = green;
    itm.blue   = blue;
    itm.ech    = entry_channel;
    itm.ex     = entry_x;
    itm.ey     = entry_y;
    itm.ez     = entry_z;
    itm.comp   = entry_component;
    itm.evalue = entry_value;
    itm.nvalue = node_value;
    keep       = 1'b0;
    unique case (opcode)
      rsc_pkg::OP_WR_COEF: begin
        itm.kind = rsc_pkg::KIND_COEF;
        keep = (entry_channel < 2'd3) && (entry_component < 2'd3)
            && (32'(entry_x) < GRID_SIZE) && (32'(entry_y) < GRID_SIZE)
            && (32'(entry_z) < GRID_SIZE);
      end
      rsc_pkg::OP_WR_NODE: begin
        itm.kind = rsc_pkg::KIND_NODE;
        keep = 32'(entry_z) < GRID_SIZE;
      end
      rsc_pkg::OP_CONVERT: begin
        itm.kind = ((red == green) && (green == blue)) ? rsc_pkg::KIND_GRAY
                                                       : rsc_pkg::KIND_COLOR;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy       = count == 2'd2;
  assign push       = start && !busy && keep;
  assign head_valid = count != 2'd0;
  assign head       = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= itm;
    end
  end

endmodule

[rtl/core/rsc_back.sv]
// back end sequencer: table writes, gray closed form, division, node search,
// trilinear interpolation; depends on rsc_pkg, rsc_ram, rsc_divider
`timescale 1ns / 1ps

module rsc_back #(
  parameter int GRID_SIZE = rsc_pkg::GRID_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  rsc_pkg::item_t     head,
  output logic               pop,
  output logic               done,
  output logic signed [39:0] coef_zero,
  output logic signed [39:0] coef_one,
  output logic signed [39:0] coef_two
);

  localparam int GW    = $clog2(GRID_SIZE);
  localparam int DEPTH = 9 * GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = 16 + GW;
  localparam int DVW   = rsc_pkg::DIV_DVD_W;
  localparam int DSW   = rsc_pkg::DIV_DSR_W;
  localparam int QW    = rsc_pkg::DIV_Q_W;
  localparam int CW    = rsc_pkg::DIV_CNT_W;
  localparam int SQW   = rsc_pkg::SQRT_W;
  localparam int LAST  = GRID_SIZE - 2;

  function automatic logic [AW-1:0] tab_addr(input logic [1:0] ch, input logic [GW:0] x,
                                             input logic [GW:0] y, input logic [GW:0] z,
                                             input logic [1:0] cp);
    int acc;
    acc = ((32'(ch) * GRID_SIZE + 32'(x)) * GRID_SIZE + 32'(y)) * GRID_SIZE + 32'(z);
    return AW'(acc * 3 + 32'(cp));
  endfunction

  rsc_pkg::back_state_t state, state_next;

  // ram and divider hookup
  logic           c_we;
  logic [AW-1:0]  c_waddr, c_raddr;
  logic [39:0]    c_rdata;
  logic           n_we;
  logic [GW-1:0]  n_waddr, n_raddr;
  logic [15:0]    n_rdata;
  logic           d_start, d_done;
  logic [DVW-1:0] d_dividend;
  logic [DSW-1:0] d_divisor;
  logic [CW-1:0]  d_nbits;
  logic [QW-1:0]  d_quot;

  // datapath registers
  logic [1:0]         maxc;
  logic [15:0]        zv, av, bv;
  logic               gneg;
  logic [14:0]        gabs;
  logic [SQW-1:0]     sq_n, sq_res, sq_bit;
  logic [XW-1:0]      xq, yq;
  logic [GW-1:0]      xi, yi, zi;
  logic [16:0]        dx, dy, dz;
  logic [GW:0]        s_first, s_size;
  logic [15:0]        n0, n1;
  logic [1:0]         comp_i;
  logic [2:0]         k;
  logic [1:0]         lvl;
  logic signed [39:0] ra, p0, q0, la, lb;
  logic [16:0]        lt;
  logic signed [58:0] prod;
  logic signed [39:0] res0, res1, res2;

  // combinational helpers
  logic [1:0]         maxc_c;
  logic [15:0]        z_c, a_c, b_c;
  logic signed [16:0] gnum;
  logic [SQW-1:0]     sq_t;
  logic               sq_ge;
  logic [GW:0]        s_half, s_mid, s_fin;
  logic signed [16:0] dz_num, dz_den;
  logic               dz_zero, dz_one;
  logic [GW-1:0]      xi_c, yi_c;
  logic signed [40:0] diff;
  logic signed [17:0] tsig;
  logic signed [41:0] rnd, la_w, lsum;
  logic signed [39:0] lres;
  logic signed [39:0] gq;
  logic               gray_sat;

  rsc_ram #(.WIDTH(40), .DEPTH(DEPTH)) u_coef_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(head.evalue),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  rsc_ram #(.WIDTH(16), .DEPTH(GRID_SIZE)) u_node_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(head.nvalue),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  rsc_divider u_div (
    .clk(clk), .rst(rst), .start(d_start), .dividend(d_dividend),
    .divisor(d_divisor), .nbits(d_nbits), .done(d_done), .quotient(d_quot)
  );

  // channel ordering, ties go to the later channel
  always_comb begin
    if (head.red > head.green) begin
      maxc_c = (head.red > head.blue) ? 2'd0 : 2'd2;
    end else begin
      maxc_c = (head.green > head.blue) ? 2'd1 : 2'd2;
    end
    unique case (maxc_c)
      2'd0: begin z_c = head.red;   a_c = head.green; b_c = head.blue;  end
      2'd1: begin z_c = head.green; a_c = head.blue;  b_c = head.red;   end
      default: begin z_c = head.blue; a_c = head.red; b_c = head.green; end
    endcase
  end

  assign gnum     = $signed({1'b0, head.red}) - $signed({1'b0, rsc_pkg::HALF_Q15});
  assign gray_sat = (head.red == 16'd0) || ({1'b0, head.red} >= rsc_pkg::ONE_Q15);

  assign sq_t  = sq_res + sq_bit;
  assign sq_ge = sq_n >= sq_t;

  assign s_half = s_size >> 1;
  assign s_mid  = s_first + s_half;
  assign s_fin  = ((s_first - 1'b1) > (GW + 1)'(LAST)) ? (GW + 1)'(LAST) : (s_first - 1'b1);

  assign dz_num  = $signed({1'b0, zv}) - $signed({1'b0, n0});
  assign dz_den  = $signed({1'b0, n1}) - $signed({1'b0, n0});
  assign dz_zero = (dz_den <= 17'sd0) || (dz_num <= 17'sd0);
  assign dz_one  = dz_num >= dz_den;

  assign xi_c = (32'(xq[XW-1:16]) > LAST) ? GW'(LAST) : xq[XW-1:16];
  assign yi_c = (32'(yq[XW-1:16]) > LAST) ? GW'(LAST) : yq[XW-1:16];

  // lerp unit: the product is registered in ST_L_MUL, the rounding add follows in ST_L_ADD
  assign diff = lb - la;
  assign tsig = $signed({1'b0, lt});
  assign rnd  = 42'((prod + 59'sd32768) >>> 16);
  assign la_w = la;
  assign lsum = la_w + rnd;
  assign lres = lsum[39:0];

  assign gq = gneg ? -$signed(d_quot[39:0]) : $signed(d_quot[39:0]);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rsc_pkg::ST_IDLE: begin
        if (head_valid) begin
          unique case (head.kind)
            rsc_pkg::KIND_GRAY:  state_next = gray_sat ? rsc_pkg::ST_OUT : rsc_pkg::ST_SQRT;
            rsc_pkg::KIND_COLOR: state_next = rsc_pkg::ST_XDIV_GO;
            default:             state_next = rsc_pkg::ST_IDLE;
          endcase
        end
      end
      rsc_pkg::ST_SQRT:      if (sq_bit == '0) state_next = rsc_pkg::ST_GDIV_GO;
      rsc_pkg::ST_GDIV_GO:   state_next = rsc_pkg::ST_GDIV_WAIT;
      rsc_pkg::ST_GDIV_WAIT: if (d_done) state_next = rsc_pkg::ST_OUT;
      rsc_pkg::ST_XDIV_GO:   state_next = rsc_pkg::ST_XDIV_WAIT;
      rsc_pkg::ST_XDIV_WAIT: if (d_done) state_next = rsc_pkg::ST_YDIV_GO;
      rsc_pkg::ST_YDIV_GO:   state_next = rsc_pkg::ST_YDIV_WAIT;
      rsc_pkg::ST_YDIV_WAIT: if (d_done) state_next = rsc_pkg::ST_CELL;
      rsc_pkg::ST_CELL:      state_next = rsc_pkg::ST_SRCH_RD;
      rsc_pkg::ST_SRCH_RD:   state_next = (s_size == '0) ? rsc_pkg::ST_N0_RD
                                                         : rsc_pkg::ST_SRCH_CMP;
      rsc_pkg::ST_SRCH_CMP:  state_next = rsc_pkg::ST_SRCH_RD;
      rsc_pkg::ST_N0_RD:     state_next = rsc_pkg::ST_N1_RD;
      rsc_pkg::ST_N1_RD:     state_next = rsc_pkg::ST_N_CAP;
      rsc_pkg::ST_N_CAP:     state_next = rsc_pkg::ST_DZ_CHK;
      rsc_pkg::ST_DZ_CHK:    state_next = (dz_zero || dz_one) ? rsc_pkg::ST_T_RD
                                                              : rsc_pkg::ST_DZ_WAIT;
      rsc_pkg::ST_DZ_WAIT:   if (d_done) state_next = rsc_pkg::ST_T_RD;
      rsc_pkg::ST_T_RD:      state_next = rsc_pkg::ST_T_CAP;
      rsc_pkg::ST_T_CAP:     state_next = k[0] ? rsc_pkg::ST_L_MUL : rsc_pkg::ST_T_RD;
      rsc_pkg::ST_L_MUL:     state_next = rsc_pkg::ST_L_ADD;
      rsc_pkg::ST_L_ADD: begin
        unique case (lvl)
          2'd0:    state_next = k[1] ? rsc_pkg::ST_L_MUL : rsc_pkg::ST_T_RD;
          2'd1:    state_next = k[2] ? rsc_pkg::ST_L_MUL : rsc_pkg::ST_T_RD;
          default: state_next = (comp_i == 2'd2) ? rsc_pkg::ST_OUT : rsc_pkg::ST_T_RD;
        endcase
      end
      rsc_pkg::ST_OUT:       state_next = rsc_pkg::ST_IDLE;
      default:               state_next = rsc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop        = (state == rsc_pkg::ST_IDLE) && head_valid;
    c_we       = pop && (head.kind == rsc_pkg::KIND_COEF);
    n_we       = pop && (head.kind == rsc_pkg::KIND_NODE);
    c_waddr    = tab_addr(head.ech, (GW + 1)'(head.ex), (GW + 1)'(head.ey),
                          (GW + 1)'(head.ez), head.comp);
    n_waddr    = GW'(head.ez);
    c_raddr    = tab_addr(maxc, {1'b0, xi} + (GW + 1)'(k[0]), {1'b0, yi} + (GW + 1)'(k[1]),
                          {1'b0, zi} + (GW + 1)'(k[2]), comp_i);
    n_raddr    = s_mid[GW-1:0];
    d_start    = 1'b0;
    d_dividend = (DVW'(gabs) << 36) + DVW'(sq_res[22:1]);
    d_divisor  = DSW'(sq_res[22:0]);
    d_nbits    = CW'(rsc_pkg::GRAY_QBITS);
    done       = state == rsc_pkg::ST_OUT;
    unique case (state)
      rsc_pkg::ST_GDIV_GO: d_start = 1'b1;
      rsc_pkg::ST_XDIV_GO: begin
        d_start    = 1'b1;
        d_dividend = (DVW'(av) * DVW'(GRID_SIZE - 1)) << 16;
        d_divisor  = DSW'(zv);
        d_nbits    = CW'(XW);
      end
      rsc_pkg::ST_YDIV_GO: begin
        d_start    = 1'b1;
        d_dividend = (DVW'(bv) * DVW'(GRID_SIZE - 1)) << 16;
        d_divisor  = DSW'(zv);
        d_nbits    = CW'(XW);
      end
      rsc_pkg::ST_DZ_CHK: begin
        d_start    = !(dz_zero || dz_one);
        d_dividend = DVW'(dz_num[15:0]) << 16;
        d_divisor  = DSW'(dz_den[15:0]);
        d_nbits    = CW'(rsc_pkg::DZ_QBITS);
      end
      rsc_pkg::ST_N0_RD: n_raddr = zi;
      rsc_pkg::ST_N1_RD: n_raddr = zi + GW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      rsc_pkg::ST_IDLE: begin
        maxc   <= maxc_c;
        zv     <= z_c;
        av     <= a_c;
        bv     <= b_c;
        gneg   <= gnum < 17'sd0;
        gabs   <= (gnum < 17'sd0) ? 15'(-gnum) : gnum[14:0];
        sq_n   <= SQW'(32'(head.red) * (32'd32768 - 32'(head.red))) << 16;
        sq_res <= '0;
        sq_bit <= SQW'(1) << 44;
        res0   <= '0;
        res1   <= '0;
        res2   <= (head.red == 16'd0) ? rsc_pkg::COEF_MIN : rsc_pkg::COEF_MAX;
      end
      rsc_pkg::ST_SQRT: begin
        if (sq_bit != '0) begin
          if (sq_ge) begin
            sq_n   <= sq_n - sq_t;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
      end
      rsc_pkg::ST_GDIV_WAIT: if (d_done) res2 <= gq;
      rsc_pkg::ST_XDIV_WAIT: if (d_done) xq <= d_quot[XW-1:0];
      rsc_pkg::ST_YDIV_WAIT: if (d_done) yq <= d_quot[XW-1:0];
      rsc_pkg::ST_CELL: begin
        xi      <= xi_c;
        yi      <= yi_c;
        dx      <= 17'(xq - (XW'(xi_c) << 16));
        dy      <= 17'(yq - (XW'(yi_c) << 16));
        s_first <= (GW + 1)'(1);
        s_size  <= (GW + 1)'(LAST);
        comp_i  <= 2'd0;
        k       <= 3'd0;
      end
      rsc_pkg::ST_SRCH_RD: if (s_size == '0) zi <= s_fin[GW-1:0];
      rsc_pkg::ST_SRCH_CMP: begin
        if (n_rdata < zv) begin
          s_first <= s_mid + 1'b1;
          s_size  <= s_size - (s_half + 1'b1);
        end else begin
          s_size  <= s_half;
        end
      end
      rsc_pkg::ST_N1_RD: n0 <= n_rdata;
      rsc_pkg::ST_N_CAP: n1 <= n_rdata;
      rsc_pkg::ST_DZ_CHK: begin
        if (dz_zero) begin
          dz <= '0;
        end else if (dz_one) begin
          dz <= rsc_pkg::ONE_Q16;
        end
      end
      rsc_pkg::ST_DZ_WAIT: if (d_done) dz <= d_quot[16:0];
      rsc_pkg::ST_T_CAP: begin
        if (k[0]) begin
          la  <= ra;
          lb  <= $signed(c_rdata);
          lt  <= dx;
          lvl <= 2'd0;
        end else begin
          ra <= $signed(c_rdata);
          k  <= k + 3'd1;
        end
      end
      rsc_pkg::ST_L_MUL: prod <= diff * tsig;
      rsc_pkg::ST_L_ADD: begin
        unique case (lvl)
          2'd0: begin
            if (k[1]) begin
              la  <= p0;
              lb  <= lres;
              lt  <= dy;
              lvl <= 2'd1;
            end else begin
              p0 <= lres;
              k  <= k + 3'd1;
            end
          end
          2'd1: begin
            if (k[2]) begin
              la  <= q0;
              lb  <= lres;
              lt  <= dz;
              lvl <= 2'd2;
            end else begin
              q0 <= lres;
              k  <= k + 3'd1;
            end
          end
          default: begin
            case (comp_i)
              2'd0:    res0 <= lres;
              2'd1:    res1 <= lres;
              default: res2 <= lres;
            endcase
            comp_i <= comp_i + 2'd1;
            k      <= 3'd0;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign coef_zero = res0;
  assign coef_one  = res1;
  assign coef_two  = res2;

endmodule
